### rtl/lpsg_pkg.sv
package lpsg_pkg;

  localparam int ANGLE_ITERATIONS_DEF = 16;

  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  localparam logic signed [26:0] TURN_Q16     = 27'sd23592960;
  localparam logic signed [26:0] TWO_TURN_Q16 = 27'sd47185920;
  localparam logic signed [26:0] HALF_TURN_Q16 = 27'sd11796480;

  localparam logic [24:0] RECIP45_M = 25'd23860929;
  localparam logic [14:0] RECIP45_S = 15'd23301;

  localparam logic signed [32:0] QUARTER_BAM = 33'sd1073741824;
  localparam logic signed [32:0] HALF_BAM    = 33'sd2147483648;
  localparam logic signed [32:0] CORDIC_X0   = 33'sd652032874;

  localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
  localparam logic signed [33:0] POLE_DEN_MIN = 34'sd64;
  localparam logic signed [65:0] ROUND_HALF   = 66'sd536870912;

  localparam logic signed [35:0] COL_OFFSET = 36'sd102656;
  localparam logic signed [35:0] ROW_OFFSET = 36'sd409856;
  localparam logic signed [23:0] OUT_MAX    = 24'sh7fffff;
  localparam logic signed [23:0] OUT_MIN    = 24'sh800000;

  localparam logic [23:0] GRID_SCALE_RST = 24'd639073;
  localparam logic [24:0] STD_LON_RST    = 25'd6881280;

  typedef enum logic {
    CFG_STD_LON    = 1'b0,
    CFG_GRID_SCALE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [32:0] z;
    logic               neg;
  } ang_t;

  typedef struct packed {
    logic signed [32:0] s;
    logic signed [32:0] c;
  } sc_t;

  typedef struct packed {
    logic signed [32:0] sa;
    logic signed [32:0] ca;
    logic               pole;
    logic               big;
    logic               neg;
  } div_side_t;

endpackage

### rtl/latlon_to_polar_stereo_grid_top.sv
// channel   direction  handshake              payload
// in_       input      in_valid / in_ready    in_lat_deg, in_lon_deg
// out_      output     out_valid / out_ready  out_grid_row, out_grid_col, out_out_of_range
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// one transaction per cycle unless a held result stalls the pipeline; stages: angle reduction (5),
// cordic (ANGLE_ITERATIONS + 1), the 32 stage divider and five further register stages
// synchronous active-low reset clears all valid bits and loads register defaults
// a held result stalls the whole pipeline; nothing is dropped or repeated
module latlon_to_polar_stereo_grid_top #(
  parameter int ANGLE_ITERATIONS = lpsg_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_lat_deg,
  input  logic signed [24:0] in_lon_deg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_grid_row,
  output logic signed [23:0] out_grid_col,
  output logic               out_out_of_range,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [24:0]        cfg_wdata
);

  logic        en;
  logic [24:0] std_lon_r;
  logic [23:0] grid_scale_r;

  logic signed [26:0] lat27, a27;
  logic vld_al, vld_aa, vld_cl, vld_ca;
  lpsg_pkg::ang_t ang_l, ang_a;
  lpsg_pkg::sc_t  sc_l, sc_a;

  logic               vld_p_r;
  logic signed [57:0] num_p_r;
  logic signed [33:0] den_p_r;
  logic signed [32:0] sa_p_r, ca_p_r;

  logic                vld_q_r;
  logic [55:0]         num_q_r;
  logic [32:0]         den_q_r;
  lpsg_pkg::div_side_t side_q_r;
  logic [57:0]         nmag;

  logic                vld_d;
  logic [31:0]         q_d;
  lpsg_pkg::div_side_t side_d;

  logic               vld_m_r;
  logic signed [65:0] pc_m_r, pr_m_r;
  logic               neg_m_r, flag_m_r, pole_m_r;

  logic               vld_n_r;
  logic signed [35:0] col_n_r, row_n_r;
  logic               flag_n_r, pole_n_r;
  logic signed [65:0] tc, tr;

  logic               out_valid_r;
  logic signed [23:0] row_r, col_r;
  logic               oor_r, pole_c_r;
  logic signed [23:0] row_nxt, col_nxt;
  logic               oor_nxt;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      std_lon_r    <= lpsg_pkg::STD_LON_RST;
      grid_scale_r <= lpsg_pkg::GRID_SCALE_RST;
    end else if (cfg_valid) begin
      unique case (lpsg_pkg::cfg_idx_t'(cfg_index))
        lpsg_pkg::CFG_STD_LON:    std_lon_r    <= cfg_wdata;
        lpsg_pkg::CFG_GRID_SCALE: grid_scale_r <= cfg_wdata[23:0];
      endcase
    end
  end

  assign lat27 = $signed({{3{in_lat_deg[23]}}, in_lat_deg});
  assign a27   = $signed({{2{in_lon_deg[24]}}, in_lon_deg}) + lpsg_pkg::HALF_TURN_Q16
               - $signed({{2{std_lon_r[24]}}, std_lon_r});

  lpsg_angle u_ang_lat (
    .clk, .rst_n, .en, .vld_i(in_valid), .deg_i(lat27), .vld_o(vld_al), .ang_o(ang_l)
  );
  lpsg_angle u_ang_lon (
    .clk, .rst_n, .en, .vld_i(in_valid), .deg_i(a27), .vld_o(vld_aa), .ang_o(ang_a)
  );

  lpsg_cordic #(.ITER(ANGLE_ITERATIONS)) u_cordic_lat (
    .clk, .rst_n, .en, .vld_i(vld_al), .ang_i(ang_l), .vld_o(vld_cl), .sc_o(sc_l)
  );
  lpsg_cordic #(.ITER(ANGLE_ITERATIONS)) u_cordic_lon (
    .clk, .rst_n, .en, .vld_i(vld_aa), .ang_i(ang_a), .vld_o(vld_ca), .sc_o(sc_a)
  );

  // numerator and denominator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_p_r <= 1'b0;
    end else if (en) begin
      vld_p_r <= vld_cl && vld_ca;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_p_r <= $signed({1'b0, grid_scale_r}) * sc_l.c;
      den_p_r <= lpsg_pkg::ONE_Q30 + $signed({sc_l.s[32], sc_l.s});
      sa_p_r  <= sc_a.s;
      ca_p_r  <= sc_a.c;
    end
  end

  // pole and range checks
  assign nmag = num_p_r[57] ? 58'(-num_p_r) : num_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_q_r <= 1'b0;
    end else if (en) begin
      vld_q_r <= vld_p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_q_r       <= nmag[55:0];
      den_q_r       <= den_p_r[32:0];
      side_q_r.sa   <= sa_p_r;
      side_q_r.ca   <= ca_p_r;
      side_q_r.pole <= den_p_r < lpsg_pkg::POLE_DEN_MIN;
      side_q_r.big  <= {7'd0, nmag} >= {den_p_r[32:0], 32'd0};
      side_q_r.neg  <= num_p_r[57];
    end
  end

  lpsg_div u_div (
    .clk, .rst_n, .en, .vld_i(vld_q_r), .num_i(num_q_r), .den_i(den_q_r),
    .side_i(side_q_r), .vld_o(vld_d), .q_o(q_d), .side_o(side_d)
  );

  // projection products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_m_r <= 1'b0;
    end else if (en) begin
      vld_m_r <= vld_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_m_r   <= $signed({1'b0, q_d}) * side_d.sa;
      pr_m_r   <= $signed({1'b0, q_d}) * side_d.ca;
      neg_m_r  <= side_d.neg;
      flag_m_r <= side_d.pole || side_d.big;
      pole_m_r <= side_d.pole;
    end
  end

  // round to q8 and add grid offsets
  assign tc = (neg_m_r ? -pc_m_r : pc_m_r) + lpsg_pkg::ROUND_HALF;
  assign tr = (neg_m_r ? -pr_m_r : pr_m_r) + lpsg_pkg::ROUND_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_n_r <= 1'b0;
    end else if (en) begin
      vld_n_r <= vld_m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_n_r  <= tc[65:30] + lpsg_pkg::COL_OFFSET;
      row_n_r  <= tr[65:30] + lpsg_pkg::ROW_OFFSET;
      flag_n_r <= flag_m_r;
      pole_n_r <= pole_m_r;
    end
  end

  // saturation
  always_comb begin
    oor_nxt = flag_n_r;
    if (flag_n_r) begin
      row_nxt = lpsg_pkg::OUT_MAX;
      col_nxt = lpsg_pkg::OUT_MAX;
    end else begin
      if (row_n_r > 36'(lpsg_pkg::OUT_MAX)) begin
        row_nxt = lpsg_pkg::OUT_MAX;
        oor_nxt = 1'b1;
      end else if (row_n_r < 36'(lpsg_pkg::OUT_MIN)) begin
        row_nxt = lpsg_pkg::OUT_MIN;
        oor_nxt = 1'b1;
      end else begin
        row_nxt = row_n_r[23:0];
      end
      if (col_n_r > 36'(lpsg_pkg::OUT_MAX)) begin
        col_nxt = lpsg_pkg::OUT_MAX;
        oor_nxt = 1'b1;
      end else if (col_n_r < 36'(lpsg_pkg::OUT_MIN)) begin
        col_nxt = lpsg_pkg::OUT_MIN;
        oor_nxt = 1'b1;
      end else begin
        col_nxt = col_n_r[23:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      oor_r    <= oor_nxt;
      pole_c_r <= pole_n_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_grid_row     = row_r;
  assign out_grid_col     = col_r;
  assign out_out_of_range = oor_r;

`ifndef SYNTH
  a_pole_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && pole_c_r |->
      out_out_of_range && (row_r == lpsg_pkg::OUT_MAX) && (col_r == lpsg_pkg::OUT_MAX))
    else $error("pole result not saturated");
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");
  a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> out_valid_r && $stable(row_r) && $stable(col_r) && $stable(oor_r))
    else $error("result changed during stall");
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    vld_cl == vld_ca)
    else $error("cordic lanes out of step");
`endif

endmodule

### rtl/lpsg_angle.sv
module lpsg_angle (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic signed [26:0] deg_i,
  output logic               vld_o,
  output lpsg_pkg::ang_t     ang_o
);

  logic [4:0]  vld_r;
  logic [24:0] m1_r;
  logic [49:0] p2_r;
  logic [24:0] m2_r;
  logic [18:0] q3_r;
  logic [5:0]  rm3_r;
  logic [33:0] p4_r;
  logic [18:0] v4_r;
  logic [18:0] q4_r;
  lpsg_pkg::ang_t ang_r;

  logic signed [26:0] m_tmp;
  logic [18:0] q0;
  logic [24:0] rem25;
  logic [6:0]  rem7;
  logic [18:0] q3_nxt;
  logic [5:0]  rm3_nxt;
  logic [18:0] v4_nxt;
  logic [12:0] t0;
  logic [18:0] r2;
  logic [12:0] t;
  logic signed [32:0] zs;
  lpsg_pkg::ang_t ang_nxt;

  // reduce to one turn
  always_comb begin
    if (deg_i < 27'sd0) begin
      m_tmp = deg_i + lpsg_pkg::TURN_Q16;
    end else if (deg_i >= lpsg_pkg::TWO_TURN_Q16) begin
      m_tmp = deg_i - lpsg_pkg::TWO_TURN_Q16;
    end else if (deg_i >= lpsg_pkg::TURN_Q16) begin
      m_tmp = deg_i - lpsg_pkg::TURN_Q16;
    end else begin
      m_tmp = deg_i;
    end
  end

  // m / 45 with one correction
  always_comb begin
    q0    = p2_r[48:30];
    rem25 = m2_r - ({6'd0, q0} * 25'd45);
    rem7  = rem25[6:0];
    if (rem7 >= 7'd45) begin
      q3_nxt  = q0 + 19'd1;
      rm3_nxt = 6'(rem7 - 7'd45);
    end else begin
      q3_nxt  = q0;
      rm3_nxt = rem7[5:0];
    end
  end

  assign v4_nxt = {rm3_r, 13'd0} + 19'd22;

  // fraction part, binary angle and fold
  always_comb begin
    t0 = p4_r[32:20];
    r2 = v4_r - ({6'd0, t0} * 19'd45);
    t  = (r2[6:0] >= 7'd45) ? (t0 + 13'd1) : t0;
    zs = $signed({q4_r[18], q4_r, t});
    if (zs > lpsg_pkg::QUARTER_BAM) begin
      ang_nxt.z   = zs - lpsg_pkg::HALF_BAM;
      ang_nxt.neg = 1'b1;
    end else if (zs < -lpsg_pkg::QUARTER_BAM) begin
      ang_nxt.z   = zs + lpsg_pkg::HALF_BAM;
      ang_nxt.neg = 1'b1;
    end else begin
      ang_nxt.z   = zs;
      ang_nxt.neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r  <= m_tmp[24:0];
      p2_r  <= {25'd0, m1_r} * {25'd0, lpsg_pkg::RECIP45_M};
      m2_r  <= m1_r;
      q3_r  <= q3_nxt;
      rm3_r <= rm3_nxt;
      p4_r  <= {15'd0, v4_nxt} * {19'd0, lpsg_pkg::RECIP45_S};
      v4_r  <= v4_nxt;
      q4_r  <= q3_r;
      ang_r <= ang_nxt;
    end
  end

  assign vld_o = vld_r[4];
  assign ang_o = ang_r;

endmodule

### rtl/lpsg_cordic.sv
module lpsg_cordic #(
  parameter int ITER = lpsg_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  lpsg_pkg::ang_t ang_i,
  output logic           vld_o,
  output lpsg_pkg::sc_t  sc_o
);

  logic signed [32:0] x_r [ITER];
  logic signed [32:0] y_r [ITER];
  logic signed [32:0] z_r [ITER];
  logic               neg_r [ITER];
  logic               vld_r [ITER];
  logic               vld_out_r;
  lpsg_pkg::sc_t      sc_r;

  for (genvar k = 0; k < ITER; k++) begin : g_it
    logic signed [32:0] xp, yp, zp, at;
    logic np, vp;
    if (k == 0) begin : g_first
      assign xp = lpsg_pkg::CORDIC_X0;
      assign yp = '0;
      assign zp = ang_i.z;
      assign np = ang_i.neg;
      assign vp = vld_i;
    end else begin : g_next
      assign xp = x_r[k-1];
      assign yp = y_r[k-1];
      assign zp = z_r[k-1];
      assign np = neg_r[k-1];
      assign vp = vld_r[k-1];
    end
    assign at = $signed({3'b000, lpsg_pkg::ATAN_TAB[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[k] <= np;
        if (zp >= 33'sd0) begin
          x_r[k] <= xp - (yp >>> k);
          y_r[k] <= yp + (xp >>> k);
          z_r[k] <= zp - at;
        end else begin
          x_r[k] <= xp + (yp >>> k);
          y_r[k] <= yp - (xp >>> k);
          z_r[k] <= zp + at;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else if (en) begin
      vld_out_r <= vld_r[ITER-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r.s <= neg_r[ITER-1] ? -y_r[ITER-1] : y_r[ITER-1];
      sc_r.c <= neg_r[ITER-1] ? -x_r[ITER-1] : x_r[ITER-1];
    end
  end

  assign vld_o = vld_out_r;
  assign sc_o  = sc_r;

`ifndef SYNTH
  a_cordic_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_out_r |-> (sc_r.c < 33'sd1207959552) && (sc_r.c > -33'sd1207959552))
    else $error("cordic cosine out of bound");
`endif

endmodule

### rtl/lpsg_div.sv
module lpsg_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  logic [55:0]         num_i,
  input  logic [32:0]         den_i,
  input  lpsg_pkg::div_side_t side_i,
  output logic                vld_o,
  output logic [31:0]         q_o,
  output lpsg_pkg::div_side_t side_o
);

  logic [32:0]         rem_r  [32];
  logic [31:0]         lo_r   [32];
  logic [31:0]         q_r    [32];
  logic [32:0]         d_r    [32];
  lpsg_pkg::div_side_t side_r [32];
  logic                vld_r  [32];

  for (genvar k = 0; k < 32; k++) begin : g_bit
    logic [32:0] rem_p, d_p;
    logic [31:0] lo_p, q_p;
    lpsg_pkg::div_side_t side_p;
    logic vld_p;
    logic [33:0] rs, diff;
    logic take;
    if (k == 0) begin : g_first
      assign rem_p  = {9'd0, num_i[55:32]};
      assign lo_p   = num_i[31:0];
      assign q_p    = '0;
      assign d_p    = den_i;
      assign side_p = side_i;
      assign vld_p  = vld_i;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign lo_p   = lo_r[k-1];
      assign q_p    = q_r[k-1];
      assign d_p    = d_r[k-1];
      assign side_p = side_r[k-1];
      assign vld_p  = vld_r[k-1];
    end
    assign rs   = {rem_p, lo_p[31]};
    assign diff = rs - {1'b0, d_p};
    assign take = (rs >= {1'b0, d_p});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? diff[32:0] : rs[32:0];
        lo_r[k]   <= {lo_p[30:0], 1'b0};
        q_r[k]    <= {q_p[30:0], take};
        d_r[k]    <= d_p;
        side_r[k] <= side_p;
      end
    end
  end

  assign vld_o  = vld_r[31];
  assign q_o    = q_r[31];
  assign side_o = side_r[31];

endmodule
